// ===== hw/rtl/cpg_pkg.sv =====
package cpg_pkg;

	// point coordinate width
	localparam int COORD_BITS = 16;

	// state widths
	localparam int OFFSET_BITS = 15;
	localparam int DECISION_BITS = 18;
	localparam int CENTER_BITS = 15;
	localparam int RADIUS_BITS = 14;
	localparam int CFG_DATA_BITS = 15;
	localparam int CFG_INDEX_BITS = 2;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS = 2'd2;

	// octant numbering
	localparam int OCTANT_BITS = 3;
	localparam logic [OCTANT_BITS-1:0] OCTANT_FIRST = 3'd0;
	localparam logic [OCTANT_BITS-1:0] OCTANT_LAST = 3'd7;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	// one step ready for mirroring
	typedef struct packed {
		logic signed [OFFSET_BITS-1:0] offset_x;
		logic signed [OFFSET_BITS-1:0] offset_y;
		logic                          run_done;
	} step_entry_t;

	// queue handshake towards a producer or consumer
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// ===== hw/rtl/cpg_front.sv =====
module cpg_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic                                 begin_run,
	input  logic [cpg_pkg::RADIUS_BITS-1:0]      radius,
	output logic                                 push,
	output cpg_pkg::step_entry_t                 push_entry
);

	logic signed [cpg_pkg::OFFSET_BITS-1:0]   offset_x_q;
	logic signed [cpg_pkg::OFFSET_BITS-1:0]   offset_y_q;
	logic signed [cpg_pkg::DECISION_BITS-1:0] decision_q;
	logic                                     active_q;

	logic signed [cpg_pkg::OFFSET_BITS-1:0]   x_inc;
	logic signed [cpg_pkg::OFFSET_BITS-1:0]   y_dec;
	logic signed [cpg_pkg::DECISION_BITS-1:0] x_w;
	logic signed [cpg_pkg::DECISION_BITS-1:0] y_w;
	logic signed [cpg_pkg::DECISION_BITS-1:0] r_w;
	logic signed [cpg_pkg::OFFSET_BITS-1:0]   x_n;
	logic signed [cpg_pkg::OFFSET_BITS-1:0]   y_n;
	logic signed [cpg_pkg::DECISION_BITS-1:0] d_n;
	logic                                     active_n;

	// next step of the midpoint recurrence
	always_comb begin
		x_inc = offset_x_q + cpg_pkg::OFFSET_BITS'(1);
		y_dec = offset_y_q - cpg_pkg::OFFSET_BITS'(1);
		x_w = cpg_pkg::DECISION_BITS'(x_inc);
		r_w = signed'(cpg_pkg::DECISION_BITS'(radius));
		if (begin_run) begin
			x_n = '0;
			y_n = signed'(cpg_pkg::OFFSET_BITS'(radius));
			d_n = cpg_pkg::DECISION_BITS'(3) - (r_w <<< 1);
			y_w = '0;
		end else if (decision_q[cpg_pkg::DECISION_BITS-1]) begin
			x_n = x_inc;
			y_n = offset_y_q;
			y_w = '0;
			d_n = decision_q + (x_w <<< 2) + cpg_pkg::DECISION_BITS'(6);
		end else begin
			x_n = x_inc;
			y_n = y_dec;
			y_w = cpg_pkg::DECISION_BITS'(y_dec);
			d_n = decision_q + ((x_w - y_w) <<< 2) + cpg_pkg::DECISION_BITS'(10);
		end
		active_n = (x_n <= y_n);
	end

	// a plain step outside a run is dropped
	assign push = accept && (begin_run || active_q);
	assign push_entry.offset_x = x_n;
	assign push_entry.offset_y = y_n;
	assign push_entry.run_done = !active_n;

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0;
			offset_y_q <= '0;
			decision_q <= '0;
			active_q <= 1'b0;
		end else if (push) begin
			offset_x_q <= x_n;
			offset_y_q <= y_n;
			decision_q <= d_n;
			active_q <= active_n;
		end
	end

endmodule

// ===== hw/rtl/cpg_queue.sv =====
module cpg_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  cpg_pkg::step_entry_t          push_entry,
	input  logic                          pop,
	output cpg_pkg::step_entry_t          head,
	output cpg_pkg::queue_status_t        status
);

	cpg_pkg::step_entry_t                     entries_q [cpg_pkg::QUEUE_DEPTH];
	logic [cpg_pkg::QUEUE_PTR_BITS-1:0]       wr_ptr_q;
	logic [cpg_pkg::QUEUE_PTR_BITS-1:0]       rd_ptr_q;
	logic [cpg_pkg::QUEUE_CNT_BITS-1:0]       count_q;
	logic                                     do_push;
	logic                                     do_pop;

	assign status.full = (count_q == cpg_pkg::QUEUE_CNT_BITS'(cpg_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop = pop && !status.empty;
	assign head = entries_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == cpg_pkg::QUEUE_PTR_BITS'(cpg_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + cpg_pkg::QUEUE_PTR_BITS'(1);
				end
			end
			if (do_pop) begin
				if (rd_ptr_q == cpg_pkg::QUEUE_PTR_BITS'(cpg_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + cpg_pkg::QUEUE_PTR_BITS'(1);
				end
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + cpg_pkg::QUEUE_CNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - cpg_pkg::QUEUE_CNT_BITS'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/cpg_back.sv =====
module cpg_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic signed [cpg_pkg::CENTER_BITS-1:0] center_x,
	input  logic signed [cpg_pkg::CENTER_BITS-1:0] center_y,
	input  cpg_pkg::step_entry_t                   head,
	input  cpg_pkg::queue_status_t                 status,
	output logic                                   pop,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [cpg_pkg::COORD_BITS-1:0]  point_x,
	output logic signed [cpg_pkg::COORD_BITS-1:0]  point_y,
	output logic [cpg_pkg::OCTANT_BITS-1:0]        octant,
	output logic                                   last_of_step,
	output logic                                   run_done
);

	cpg_pkg::step_entry_t                     entry_q;
	logic                                     busy_q;
	logic [cpg_pkg::OCTANT_BITS-1:0]          oct_q;
	logic                                     out_valid_q;
	logic signed [cpg_pkg::COORD_BITS-1:0]    point_x_q;
	logic signed [cpg_pkg::COORD_BITS-1:0]    point_y_q;
	logic [cpg_pkg::OCTANT_BITS-1:0]          octant_q;
	logic                                     last_q;
	logic                                     done_q;

	logic                                     load;
	logic                                     step_end;
	logic signed [cpg_pkg::OFFSET_BITS-1:0]   off_a;
	logic signed [cpg_pkg::OFFSET_BITS-1:0]   off_b;
	logic signed [cpg_pkg::OFFSET_BITS+1:0]   sum_x;
	logic signed [cpg_pkg::OFFSET_BITS+1:0]   sum_y;

	// output register free or being drained
	assign load = busy_q && (!out_valid_q || !out_stall);
	assign step_end = load && (oct_q == cpg_pkg::OCTANT_LAST);
	assign pop = !status.empty && (!busy_q || step_end);

	// mirror the offsets: bit 2 swaps, bit 0 negates x part, bit 1 negates y part
	always_comb begin
		off_a = oct_q[2] ? entry_q.offset_y : entry_q.offset_x;
		off_b = oct_q[2] ? entry_q.offset_x : entry_q.offset_y;
		if (oct_q[0]) begin
			sum_x = (cpg_pkg::OFFSET_BITS+2)'(center_x) - (cpg_pkg::OFFSET_BITS+2)'(off_a);
		end else begin
			sum_x = (cpg_pkg::OFFSET_BITS+2)'(center_x) + (cpg_pkg::OFFSET_BITS+2)'(off_a);
		end
		if (oct_q[1]) begin
			sum_y = (cpg_pkg::OFFSET_BITS+2)'(center_y) - (cpg_pkg::OFFSET_BITS+2)'(off_b);
		end else begin
			sum_y = (cpg_pkg::OFFSET_BITS+2)'(center_y) + (cpg_pkg::OFFSET_BITS+2)'(off_b);
		end
	end

	// current step and octant sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			oct_q <= cpg_pkg::OCTANT_FIRST;
		end else if (pop) begin
			busy_q <= 1'b1;
			oct_q <= cpg_pkg::OCTANT_FIRST;
		end else if (step_end) begin
			busy_q <= 1'b0;
			oct_q <= cpg_pkg::OCTANT_FIRST;
		end else if (load) begin
			oct_q <= oct_q + cpg_pkg::OCTANT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			entry_q <= head;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load || (out_valid_q && out_stall);
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			point_x_q <= cpg_pkg::COORD_BITS'(sum_x);
			point_y_q <= cpg_pkg::COORD_BITS'(sum_y);
			octant_q <= oct_q;
			last_q <= (oct_q == cpg_pkg::OCTANT_LAST);
			done_q <= entry_q.run_done;
		end
	end

	assign out_valid = out_valid_q;
	assign point_x = point_x_q;
	assign point_y = point_y_q;
	assign octant = octant_q;
	assign last_of_step = last_q;
	assign run_done = done_q;

endmodule

// ===== hw/rtl/circle_point_generator_core.sv =====
// Midpoint circle rasteriser with eight-way symmetry.
// Configuration: write center_x (index 0), center_y (index 1) and
// circle_radius (index 2) through cfg_write / cfg_index / cfg_data while
// the block is idle. Writes to other indexes are ignored.
// Request channel: in_valid / in_stall carries begin_run. A request with
// begin_run set starts a circle at (0, radius); a request with it clear
// advances one step of the current run, and is dropped once the run is over.
// Result channel: out_valid / out_stall carries eight points per step, in
// octant order 0 to 7, last_of_step on the eighth, run_done on all eight
// points of the step after which x exceeds y.
// Path: step queue, then the back's step register, then the result register.
// Throughput: one point per cycle while out_stall is low and a step is
// queued, set by the single result register; the front updates the run state
// in the cycle a request is taken; a two-entry step queue lets it run ahead.
// Reset clears run state, config, out_valid and queue; no run is active.
// While out_valid and out_stall are high the point on the outputs holds,
// the back stops and in_stall rises once the step queue is full.
module circle_point_generator_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [cpg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [cpg_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   begin_run,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [cpg_pkg::COORD_BITS-1:0]  point_x,
	output logic signed [cpg_pkg::COORD_BITS-1:0]  point_y,
	output logic [cpg_pkg::OCTANT_BITS-1:0]        octant,
	output logic                                   last_of_step,
	output logic                                   run_done
);

	logic signed [cpg_pkg::CENTER_BITS-1:0] center_x_q;
	logic signed [cpg_pkg::CENTER_BITS-1:0] center_y_q;
	logic [cpg_pkg::RADIUS_BITS-1:0]        radius_q;

	logic                   accept;
	logic                   push;
	logic                   pop;
	cpg_pkg::step_entry_t   push_entry;
	cpg_pkg::step_entry_t   head;
	cpg_pkg::queue_status_t status;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				cpg_pkg::REG_CENTER_X: center_x_q <= signed'(cfg_data);
				cpg_pkg::REG_CENTER_Y: center_y_q <= signed'(cfg_data);
				cpg_pkg::REG_RADIUS: radius_q <= cfg_data[cpg_pkg::RADIUS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// request handshake
	assign in_stall = status.full;
	assign accept = in_valid && !in_stall;

	cpg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.begin_run  (begin_run),
		.radius     (radius_q),
		.push       (push),
		.push_entry (push_entry)
	);

	cpg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (status)
	);

	cpg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.center_x     (center_x_q),
		.center_y     (center_y_q),
		.head         (head),
		.status       (status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.octant       (octant),
		.last_of_step (last_of_step),
		.run_done     (run_done)
	);

	// the eighth point closes a step
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_step |-> octant == cpg_pkg::OCTANT_LAST)
		else $error("last_of_step away from the final octant");

	// points within a step follow back to back in octant order
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_step |=>
		out_valid && octant == $past(octant) + cpg_pkg::OCTANT_BITS'(1))
		else $error("gap or skip inside a step");

	// run_done is the same on every point of one step
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_step |=> run_done == $past(run_done))
		else $error("run_done changed inside a step");

endmodule
